/* design/lbb_pkg.sv */
package lbb_pkg;

  // Field widths of one command transaction
  localparam int KIND_W   = 3;
  localparam int PERIOD_W = 16;
  localparam int COUNT_W  = 8;
  localparam int FLASH_W  = 16;
  localparam int PHASE_W  = FLASH_W + 1;

  // Command codes carried in the kind field
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET_OFF   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET_SOLID = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SET_BLINK = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BURST     = 3'd4;

  // Base display mode
  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_SOLID = 2'd1,
    MODE_BLINK = 2'd2
  } mode_t;

endpackage

/* design/lbb_if.sv */
// Command channel: one tick or one mode command per transaction
interface lbb_cmd_if
  import lbb_pkg::*;
(
  input logic clk
);
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [PERIOD_W-1:0] blink_period_ms;
  logic [COUNT_W-1:0]  flash_count;
  logic [FLASH_W-1:0]  flash_on_ms;
  logic [FLASH_W-1:0]  flash_off_ms;

  modport source (
    input  clk, ready,
    output valid, kind, blink_period_ms, flash_count, flash_on_ms, flash_off_ms
  );
  modport sink (
    input  clk, valid, kind, blink_period_ms, flash_count, flash_on_ms, flash_off_ms,
    output ready
  );
endinterface

// Result channel: LED level after each command transaction
interface lbb_led_if (
  input logic clk
);
  logic valid;
  logic ready;
  logic led_lit;

  modport source (
    input  clk, ready,
    output valid, led_lit
  );
  modport sink (
    input  clk, valid, led_lit,
    output ready
  );
endinterface

/* design/led_blink_burst_pattern_top.sv */
// Channel | Modport | Payload
// cmd     | sink    | kind, blink_period_ms, flash_count, flash_on_ms, flash_off_ms
// led     | source  | led_lit
//
// One command transaction per cycle; its LED level appears in the result
// register on the next cycle. The state update and level compare sit in one
// combinational pass between the state registers and the result register.
// cmd.ready stays high unless a result waits in the register while led.ready is low.
// rst (synchronous) returns to mode off, no burst, all phases zero, no result pending.
module led_blink_burst_pattern_top
  import lbb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lbb_cmd_if.sink   cmd,
  lbb_led_if.source led
);

  // Mode and phase state
  mode_t               base_mode, base_mode_next;
  logic [PERIOD_W-1:0] period_held, period_held_next;
  logic [PERIOD_W-1:0] blink_phase, blink_phase_next;
  logic [COUNT_W-1:0]  flashes_left, flashes_left_next;
  logic [FLASH_W-1:0]  flash_on_held, flash_on_held_next;
  logic [FLASH_W-1:0]  flash_off_held, flash_off_held_next;
  logic [PHASE_W-1:0]  flash_phase, flash_phase_next;

  // Result register
  logic out_valid;
  logic out_lit;
  logic lit_next;

  logic                accept;
  logic [PHASE_W-1:0]  flash_cycle;
  logic                burst_active;
  logic [PHASE_W:0]    flash_step;
  logic [PERIOD_W:0]   blink_step;
  logic [PHASE_W-1:0]  cycle_next;
  logic                burst_active_next;

  assign cmd.ready = !out_valid || led.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign flash_cycle  = {1'b0, flash_on_held} + {1'b0, flash_off_held};
  assign burst_active = (flashes_left != '0) && (flash_cycle != '0);
  assign flash_step   = {1'b0, flash_phase} + {{PHASE_W{1'b0}}, 1'b1};
  assign blink_step   = {1'b0, blink_phase} + {{PERIOD_W{1'b0}}, 1'b1};

  // Apply one command or tick to the state
  always_comb begin
    base_mode_next      = base_mode;
    period_held_next    = period_held;
    blink_phase_next    = blink_phase;
    flashes_left_next   = flashes_left;
    flash_on_held_next  = flash_on_held;
    flash_off_held_next = flash_off_held;
    flash_phase_next    = flash_phase;
    case (cmd.kind)
      KIND_TICK: begin
        if (burst_active) begin
          if (flash_step >= {1'b0, flash_cycle}) begin
            flash_phase_next  = '0;
            flashes_left_next = flashes_left - COUNT_W'(1);
          end else begin
            flash_phase_next = flash_step[PHASE_W-1:0];
          end
        end
        if (base_mode == MODE_BLINK && period_held != '0) begin
          if (blink_step >= {1'b0, period_held}) begin
            blink_phase_next = '0;
          end else begin
            blink_phase_next = blink_step[PERIOD_W-1:0];
          end
        end
      end
      KIND_SET_OFF:   base_mode_next = MODE_OFF;
      KIND_SET_SOLID: base_mode_next = MODE_SOLID;
      KIND_SET_BLINK: begin
        // Same period while blinking keeps the phase
        if (!(base_mode == MODE_BLINK && period_held == cmd.blink_period_ms)) begin
          base_mode_next   = MODE_BLINK;
          period_held_next = cmd.blink_period_ms;
          blink_phase_next = '0;
        end
      end
      KIND_BURST: begin
        if (cmd.flash_count == '0) begin
          flashes_left_next = '0;
        end else begin
          flashes_left_next   = cmd.flash_count;
          flash_on_held_next  = cmd.flash_on_ms;
          flash_off_held_next = cmd.flash_off_ms;
          flash_phase_next    = '0;
        end
      end
      default: ;
    endcase
  end

  // Derive the LED level from the updated state
  assign cycle_next        = {1'b0, flash_on_held_next} + {1'b0, flash_off_held_next};
  assign burst_active_next = (flashes_left_next != '0) && (cycle_next != '0);

  always_comb begin
    if (burst_active_next) begin
      lit_next = flash_phase_next < {1'b0, flash_on_held_next};
    end else begin
      case (base_mode_next)
        MODE_SOLID: lit_next = 1'b1;
        MODE_BLINK: lit_next = (period_held_next != '0) &&
                               (blink_phase_next < (period_held_next >> 1));
        default:    lit_next = 1'b0;
      endcase
    end
  end

  // Commit state on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode      <= MODE_OFF;
      period_held    <= '0;
      blink_phase    <= '0;
      flashes_left   <= '0;
      flash_on_held  <= '0;
      flash_off_held <= '0;
      flash_phase    <= '0;
    end else if (accept) begin
      base_mode      <= base_mode_next;
      period_held    <= period_held_next;
      blink_phase    <= blink_phase_next;
      flashes_left   <= flashes_left_next;
      flash_on_held  <= flash_on_held_next;
      flash_off_held <= flash_off_held_next;
      flash_phase    <= flash_phase_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (led.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_lit <= lit_next;
    end
  end

  assign led.valid   = out_valid;
  assign led.led_lit = out_lit;

endmodule

/* design/lbb_check.sv */
module lbb_check (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic led_valid,
  input logic led_ready,
  input logic led_lit
);

  // Drop any pending result on reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !led_valid)
    else $error("result pending after reset");

  // Every accepted command yields a result on the next cycle
  a_cmd_result: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> led_valid)
    else $error("accepted command produced no result");

  // Block new commands while a result is stalled
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (led_valid && !led_ready) |-> !cmd_ready)
    else $error("command accepted over a stalled result");

  // Hold a stalled result steady
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (led_valid && !led_ready) |=> (led_valid && $stable(led_lit)))
    else $error("stalled result changed");

endmodule

bind led_blink_burst_pattern_top lbb_check u_lbb_check (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .led_valid (led.valid),
  .led_ready (led.ready),
  .led_lit   (led.led_lit)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lbb_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RST_CYCLES  = 9;
  localparam int RAND_ITEMS  = 1150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 4;
  localparam int HALF_DIV    = 2;

  // Kinds with no meaning; the block must report the level unchanged
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [PERIOD_W-1:0] period;
    logic [COUNT_W-1:0]  count;
    logic [FLASH_W-1:0]  on_ms;
    logic [FLASH_W-1:0]  off_ms;
  } cmd_t;

  // Track the LED state per command and hold the expected levels in order
  class led_scoreboard;
    mode_t               base_mode;
    logic [PERIOD_W-1:0] period_held;
    logic [PERIOD_W-1:0] blink_phase;
    logic [COUNT_W-1:0]  flashes_left;
    logic [FLASH_W-1:0]  on_held;
    logic [FLASH_W-1:0]  off_held;
    logic [PHASE_W-1:0]  flash_phase;
    bit                  level_q[$];
    int                  errors;

    function new();
      base_mode    = MODE_OFF;
      period_held  = '0;
      blink_phase  = '0;
      flashes_left = '0;
      on_held      = '0;
      off_held     = '0;
      flash_phase  = '0;
      errors       = 0;
    endfunction

    function int flash_len();
      return int'(on_held) + int'(off_held);
    endfunction

    function bit burst_running();
      return flashes_left != '0 && flash_len() != 0;
    endfunction

    function bit lit_now();
      if (burst_running()) return int'(flash_phase) < int'(on_held);
      if (base_mode == MODE_SOLID) return 1'b1;
      if (base_mode == MODE_BLINK) begin
        if (period_held == '0) return 1'b0;
        return int'(blink_phase) < int'(period_held) / HALF_DIV;
      end
      return 1'b0;
    endfunction

    // Advance both phase counters by one millisecond
    function void advance_ms();
      int nxt;
      if (burst_running()) begin
        nxt = int'(flash_phase) + 1;
        if (nxt >= flash_len()) begin
          flash_phase  = '0;
          flashes_left = flashes_left - 1'b1;
        end else begin
          flash_phase = nxt[PHASE_W-1:0];
        end
      end
      if (base_mode == MODE_BLINK && period_held != '0) begin
        nxt = int'(blink_phase) + 1;
        blink_phase = (nxt >= int'(period_held)) ? '0 : nxt[PERIOD_W-1:0];
      end
    endfunction

    function void note_command(cmd_t c);
      case (c.kind)
        KIND_TICK: advance_ms();
        KIND_SET_OFF: base_mode = MODE_OFF;
        KIND_SET_SOLID: base_mode = MODE_SOLID;
        KIND_SET_BLINK: begin
          if (!(base_mode == MODE_BLINK && period_held == c.period)) begin
            base_mode   = MODE_BLINK;
            period_held = c.period;
            blink_phase = '0;
          end
        end
        KIND_BURST: begin
          if (c.count == '0) begin
            flashes_left = '0;
          end else begin
            flashes_left = c.count;
            on_held      = c.on_ms;
            off_held     = c.off_ms;
            flash_phase  = '0;
          end
        end
        default: ;
      endcase
      level_q.push_back(lit_now());
    endfunction

    function void check_level(bit lit);
      bit want;
      if (level_q.size() == 0) begin
        $error("led_lit: unexpected transaction, actual %0d", lit);
        errors++;
        return;
      end
      want = level_q.pop_front();
      if (want != lit) begin
        $error("led_lit mismatch: expected %0d, actual %0d", want, lit);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbb_cmd_if cmd_ch (.clk(clk));
  lbb_led_if led_ch (.clk(clk));

  led_blink_burst_pattern_top u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .led (led_ch)
  );

  led_scoreboard       sb = new();
  int                  gap_pct;
  int                  stall_pct;
  int                  stall_left;
  int                  cycles = 0;
  logic [PERIOD_W-1:0] last_period;

  always #CLK_HALF clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic cmd_t mk(logic [KIND_W-1:0] kind, int period, int count,
                              int on_ms, int off_ms);
    cmd_t c;
    c.kind   = kind;
    c.period = period[PERIOD_W-1:0];
    c.count  = count[COUNT_W-1:0];
    c.on_ms  = on_ms[FLASH_W-1:0];
    c.off_ms = off_ms[FLASH_W-1:0];
    return c;
  endfunction

  // Mostly ticks; fields a command ignores carry random junk
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   r;
    c.kind   = KIND_TICK;
    c.period = PERIOD_W'($urandom);
    c.count  = COUNT_W'($urandom);
    c.on_ms  = FLASH_W'($urandom);
    c.off_ms = FLASH_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 66) begin
      c.kind = KIND_TICK;
    end else if (r < 71) begin
      c.kind = KIND_SET_OFF;
    end else if (r < 76) begin
      c.kind = KIND_SET_SOLID;
    end else if (r < 87) begin
      c.kind = KIND_SET_BLINK;
      r = $urandom_range(0, 9);
      if (r < 3) c.period = last_period;
      else if (r > 3) c.period = PERIOD_W'($urandom_range(0, 16));
    end else if (r < 97) begin
      c.kind = KIND_BURST;
      r = $urandom_range(0, 7);
      if (r == 0) c.count = '0;
      else if (r > 1) c.count = COUNT_W'($urandom_range(1, 4));
      if ($urandom_range(0, 9) != 0) c.on_ms = FLASH_W'($urandom_range(0, 6));
      if ($urandom_range(0, 9) != 0) c.off_ms = FLASH_W'($urandom_range(0, 6));
    end else begin
      c.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    end
    return c;
  endfunction

  // Drive one command and hold it until the block takes it
  task automatic send_cmd(cmd_t c);
    int gap;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = gap_len();
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid           <= 1'b1;
    cmd_ch.kind            <= c.kind;
    cmd_ch.blink_period_ms <= c.period;
    cmd_ch.flash_count     <= c.count;
    cmd_ch.flash_on_ms     <= c.on_ms;
    cmd_ch.flash_off_ms    <= c.off_ms;
    do @(posedge clk); while (!cmd_ch.ready);
    if (c.kind == KIND_SET_BLINK) last_period = c.period;
  endtask

  task automatic run_directed();
    send_cmd(mk(KIND_TICK, 0, 0, 0, 0));
    send_cmd(mk(KIND_SET_SOLID, 0, 0, 0, 0));
    send_cmd(mk(KIND_TICK, 0, 0, 0, 0));
    // empty burst lets solid show through
    send_cmd(mk(KIND_BURST, 0, 255, 0, 0));
    send_cmd(mk(KIND_TICK, 0, 0, 0, 0));
    // zero period stays dark
    send_cmd(mk(KIND_SET_BLINK, 0, 0, 0, 0));
    send_cmd(mk(KIND_TICK, 0, 0, 0, 0));
    send_cmd(mk(KIND_SET_BLINK, 65535, 0, 0, 0));
    send_cmd(mk(KIND_TICK, 0, 0, 0, 0));
    // same period keeps the phase
    send_cmd(mk(KIND_SET_BLINK, 65535, 0, 0, 0));
    send_cmd(mk(KIND_SET_BLINK, 4, 0, 0, 0));
    repeat (3) send_cmd(mk(KIND_TICK, 0, 0, 0, 0));
    // two short flashes run out and blink returns
    send_cmd(mk(KIND_BURST, 0, 2, 1, 2));
    repeat (6) send_cmd(mk(KIND_TICK, 0, 0, 0, 0));
    send_cmd(mk(KIND_BURST, 0, 1, 65535, 65535));
    send_cmd(mk(KIND_TICK, 0, 0, 0, 0));
    send_cmd(mk(KIND_BURST, 65535, 0, 65535, 65535));
    send_cmd(mk(KIND_SPARE_LO, 65535, 255, 65535, 65535));
    send_cmd(mk(KIND_SPARE_HI, 65535, 255, 65535, 65535));
    send_cmd(mk(KIND_SET_OFF, 0, 0, 0, 0));
  endtask

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst) begin
      led_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      led_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      led_ch.ready <= 1'b0;
      stall_left   <= gap_len() - 1;
    end else begin
      led_ch.ready <= 1'b1;
    end
  end

  // Watch both channels for transactions
  always @(posedge clk) begin
    if (!rst) begin
      if (led_ch.valid && led_ch.ready) sb.check_level(led_ch.led_lit);
      if (cmd_ch.valid && cmd_ch.ready) begin
        sb.note_command({cmd_ch.kind, cmd_ch.blink_period_ms, cmd_ch.flash_count,
                         cmd_ch.flash_on_ms, cmd_ch.flash_off_ms});
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int   sent;
    cmd_t c;
    last_period            = '0;
    gap_pct                = 20;
    stall_pct              = 20;
    cmd_ch.valid           <= 1'b0;
    cmd_ch.kind            <= KIND_TICK;
    cmd_ch.blink_period_ms <= '0;
    cmd_ch.flash_count     <= '0;
    cmd_ch.flash_on_ms     <= '0;
    cmd_ch.flash_off_ms    <= '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    sent = 0;
    while (sent < RAND_ITEMS) begin
      // vary the idling every so often, sometimes switching it off
      if (sent % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
      c = rand_cmd();
      send_cmd(c);
      if (c.kind <= KIND_BURST) sent++;
    end
    cmd_ch.valid <= 1'b0;

    while (sb.level_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.level_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
design/lbb_pkg.sv
design/lbb_if.sv
design/led_blink_burst_pattern_top.sv
design/lbb_check.sv
verif/tb_top.sv
